// File: src/btp_pkg.sv
// Shared types, constants and the deletion test for the thinning pass core.
// Used by every module under src except btp_ram; depends on nothing.
package btp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 8;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [PIX_W-1:0] THR_RESET    = PIX_W'(20);
    localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_PASS_SELECT  = 2'd3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PIX_W-1:0] threshold;
        logic             pass_sel;
    } cfg_t;

    typedef struct packed {
        logic              bot;
        logic              top_en;
        logic              mid_en;
        logic              col0;
        logic              emit;
        logic              last;
        logic              fwd;
        logic [1:0]        fwd_data;
        logic [ADDR_W-1:0] addr;
    } scan_item_t;

    // window bit x*3+y: column x (0 left), row y (0 top)
    function automatic logic should_delete(input logic [8:0] w, input logic pass_sel);
        logic       nw, n, ne, e, se, s, sw, wst;
        logic [2:0] cnt, n1, n2, nm;
        logic       crit;
        nw  = w[0];
        wst = w[1];
        sw  = w[2];
        n   = w[3];
        s   = w[5];
        ne  = w[6];
        e   = w[7];
        se  = w[8];
        cnt = 3'(~n & (ne | e)) + 3'(~e & (se | s)) + 3'(~s & (sw | wst))
            + 3'(~wst & (nw | n));
        n1 = 3'(nw | n) + 3'(ne | e) + 3'(se | s) + 3'(sw | wst);
        n2 = 3'(n | ne) + 3'(e | se) + 3'(s | sw) + 3'(wst | nw);
        nm = (n1 < n2) ? n1 : n2;
        if (pass_sel) begin
            crit = (s | sw | ~nw) & wst;
        end else begin
            crit = (n | ne | ~se) & e;
        end
        return w[4] && (cnt == 3'd1) && (nm == 3'd2 || nm == 3'd3) && !crit;
    endfunction

endpackage

// File: src/binary_thinning_pass_core.sv
// Top level of the Guo-Hall thinning pass core: configuration registers and
// the scan, evaluate and line-store RAM stages. Depends on btp_pkg.
//
// One request per clock unless the output is back-pressured: a request enters
// the input stage, reads the two-row line store (one RAM, read and write port
// each used once per request) and then moves into the result register.
// Each result for pixel (r,c) appears after the request one row plus one pixel
// later; after the frame send frame_width+1 flush requests, and the result
// carrying tlast reports in frame_changed whether any pixel was deleted.
// Line-store rows are read only once written in the current frame, so no
// clearing pass follows reset. Widths and heights out of range are clamped
// to 1..4096. Any register write restarts the frame; write only when idle.
module binary_thinning_pass_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] out_pixel, [1] deleted, [2] frame_changed
    output logic        m_tlast    // last_of_frame
);

    btp_pkg::cfg_t                cfg_reg, cfg_next;
    logic                         cfg_wr;
    logic                         restart;
    btp_pkg::scan_item_t          item;
    logic                         item_valid;
    logic                         take;
    logic                         rd_en, wr_en;
    logic [btp_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
    logic [1:0]                   rd_data, wr_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_wr) begin
            restart = 1'b1;
            unique case (cfg_index)
                btp_pkg::REG_FRAME_WIDTH: begin
                    if (cfg_data == '0) begin
                        cfg_next.width = btp_pkg::DIM_W'(1);
                    end else if (cfg_data > btp_pkg::WIDTH_MAX) begin
                        cfg_next.width = btp_pkg::WIDTH_MAX;
                    end else begin
                        cfg_next.width = cfg_data;
                    end
                end
                btp_pkg::REG_FRAME_HEIGHT: begin
                    if (cfg_data == '0) begin
                        cfg_next.height = btp_pkg::DIM_W'(1);
                    end else if (cfg_data > btp_pkg::HEIGHT_MAX) begin
                        cfg_next.height = btp_pkg::HEIGHT_MAX;
                    end else begin
                        cfg_next.height = cfg_data;
                    end
                end
                btp_pkg::REG_FG_THRESHOLD: cfg_next.threshold = cfg_data[7:0];
                btp_pkg::REG_PASS_SELECT:  cfg_next.pass_sel  = cfg_data[0];
                default:                   restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width     <= btp_pkg::WIDTH_RESET;
            cfg_reg.height    <= btp_pkg::HEIGHT_RESET;
            cfg_reg.threshold <= btp_pkg::THR_RESET;
            cfg_reg.pass_sel  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    btp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .restart    (restart),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .wr_data    (wr_data),
        .item       (item),
        .item_valid (item_valid),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    btp_ram #(
        .WIDTH (2),
        .DEPTH (btp_pkg::MAX_WIDTH)
    ) u_lines (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    btp_eval u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pass_sel   (cfg_reg.pass_sel),
        .restart    (restart),
        .item       (item),
        .item_valid (item_valid),
        .rd_data    (rd_data),
        .take       (take),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    a_changed_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tdata[2])
        else $error("frame_changed set on a result other than the last");

    a_deleted_clears_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("deleted pixel still reported as foreground");

    a_last_deletion_flags_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[1] |-> m_tdata[2])
        else $error("deletion on final pixel not reflected in frame_changed");

    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");
`endif

endmodule

// File: src/btp_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
// Standalone; no package dependency.
module btp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/btp_scan.sv
// Raster position counters and input stage: thresholds each request and issues
// the line-store read. Depends on btp_pkg.
module btp_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  btp_pkg::cfg_t             cfg,
    input  logic                      restart,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] pixel_value
    input  logic                      s_tuser,   // [0] req_type
    input  logic                      take,
    input  logic [1:0]                wr_data,
    output btp_pkg::scan_item_t       item,
    output logic                      item_valid,
    output logic                      rd_en,
    output logic [btp_pkg::ADDR_W-1:0] rd_addr
);

    logic [btp_pkg::DIM_W-1:0] row_reg, row_next;
    logic [btp_pkg::DIM_W-1:0] col_reg, col_next;
    logic                      valid_reg, valid_next;
    btp_pkg::scan_item_t       item_reg, item_next;
    logic                      accept;
    logic                      is_last;

    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;
    assign is_last  = (col_reg == '0) &&
                      (row_reg == btp_pkg::DIM_W'(cfg.height + btp_pkg::DIM_W'(1)));

    always_comb begin
        item_next          = item_reg;
        item_next.bot      = (row_reg < cfg.height) && (s_tuser == btp_pkg::REQ_PIXEL) &&
                             (s_tdata >= cfg.threshold);
        item_next.top_en   = row_reg >= btp_pkg::DIM_W'(2);
        item_next.mid_en   = row_reg >= btp_pkg::DIM_W'(1);
        item_next.col0     = col_reg == '0;
        item_next.emit     = (col_reg == '0) ? (row_reg >= btp_pkg::DIM_W'(2)) :
                             ((row_reg >= btp_pkg::DIM_W'(1)) && (row_reg <= cfg.height));
        item_next.last     = is_last;
        item_next.fwd      = valid_reg && (item_reg.addr == col_reg[btp_pkg::ADDR_W-1:0]);
        item_next.fwd_data = wr_data;
        item_next.addr     = col_reg[btp_pkg::ADDR_W-1:0];

        row_next   = row_reg;
        col_next   = col_reg;
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            if (is_last) begin
                row_next = '0;
                col_next = '0;
            end else if (col_reg == btp_pkg::DIM_W'(cfg.width - btp_pkg::DIM_W'(1))) begin
                row_next = btp_pkg::DIM_W'(row_reg + btp_pkg::DIM_W'(1));
                col_next = '0;
            end else begin
                col_next = btp_pkg::DIM_W'(col_reg + btp_pkg::DIM_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;
    assign rd_en      = accept;
    assign rd_addr    = col_reg[btp_pkg::ADDR_W-1:0];

endmodule

// File: src/btp_eval.sv
// 3x3 window, deletion test and result register; writes rows back to the
// line store. Depends on btp_pkg.
module btp_eval (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pass_sel,
    input  logic                       restart,
    input  btp_pkg::scan_item_t        item,
    input  logic                       item_valid,
    input  logic [1:0]                 rd_data,
    output logic                       take,
    output logic                       wr_en,
    output logic [btp_pkg::ADDR_W-1:0] wr_addr,
    output logic [1:0]                 wr_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,  // [0] out_pixel, [1] deleted,
                                                 // [2] frame_changed, [7:3] zero
    output logic                       m_tlast   // last_of_frame
);

    logic [8:0] window_reg, window_next;
    logic       any_del_reg, any_del_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       upper, middle, top, mid;
    logic [2:0] column;
    logic [8:0] shifted, evalw;
    logic       del, adv;

    assign take = !m_valid_reg || m_tready;
    assign adv  = item_valid && take;

    always_comb begin
        upper   = item.fwd ? item.fwd_data[1] : rd_data[1];
        middle  = item.fwd ? item.fwd_data[0] : rd_data[0];
        top     = item.top_en & upper;
        mid     = item.mid_en & middle;
        column  = {item.bot, mid, top};
        shifted = {3'b000, window_reg[8:3]};
        if (item.col0) begin
            window_next = {column, 6'b000000};
            evalw       = shifted;
        end else begin
            window_next = shifted | {column, 6'b000000};
            evalw       = window_next;
        end
        del          = item.emit && btp_pkg::should_delete(evalw, pass_sel);
        any_del_next = any_del_reg | del;
        if (item.last) begin
            window_next  = '0;
            any_del_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (take) begin
            m_valid_next = item_valid && item.emit;
            m_data_next  = {item.last & (any_del_reg | del), del, evalw[4] & ~del};
            m_last_next  = item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            window_reg  <= '0;
            any_del_reg <= 1'b0;
        end else if (adv) begin
            window_reg  <= window_next;
            any_del_reg <= any_del_next;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign wr_en    = adv;
    assign wr_addr  = item.addr;
    assign wr_data  = {mid, item.bot};
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule
